@@ sv/lstc_pkg.sv @@
`timescale 1ns / 1ps
// lstc_pkg: shared constants, codes and types for the line sensor threshold calibrator
// no dependencies; used by lstc_ctrl, lstc_dp and the top level
package lstc_pkg;

  localparam int EYES_PER_BAR = 8;
  localparam int BAR_COUNT    = 4;
  localparam int SAMPLE_BITS  = 10;

  localparam int EYE_TOTAL  = EYES_PER_BAR * BAR_COUNT;
  localparam int IDX_W      = $clog2(EYE_TOTAL);
  localparam int SUM_W      = SAMPLE_BITS + IDX_W;
  localparam int BYTE_COUNT = 4;
  localparam int BYTE_W     = 8;

  localparam logic [SAMPLE_BITS-1:0] THR_RESET   = SAMPLE_BITS'(500);
  localparam logic [SAMPLE_BITS-1:0] THR_LOW     = SAMPLE_BITS'(150);
  localparam logic [SAMPLE_BITS-1:0] THR_HIGH    = SAMPLE_BITS'(850);
  localparam logic [SAMPLE_BITS-1:0] WHITE_RESET = SAMPLE_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] BLACK_RESET = SAMPLE_BITS'(900);

  localparam logic [1:0] BAR_BACK  = 2'd1;
  localparam logic [1:0] BAR_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_CAPT_WHITE = 2'd1,
    REQ_CAPT_BLACK = 2'd2,
    REQ_SET_ALL    = 2'd3
  } lstc_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SWEEP,
    ST_FINISH
  } lstc_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic commit_sample;
    logic sweep_step;
    logic load_calib;
  } lstc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;
  } lstc_status_t;

endpackage

@@ sv/lstc_ctrl.sv @@
`timescale 1ns / 1ps
// lstc_ctrl: sequencing state machine and output word valid flag
// depends on lstc_pkg
module lstc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  input  logic                 out_ready_i,
  input  lstc_pkg::lstc_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output lstc_pkg::lstc_cmd_t  cmd_o
);
  import lstc_pkg::*;

  lstc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        load;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (lstc_req_e'(req_type_i) == REQ_SAMPLE) ? ST_SAMPLE : ST_SWEEP;
        end
      end
      ST_SAMPLE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        if (status_i.sweep_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      ST_SAMPLE: cmd_o.commit_sample = slot_free;
      ST_SWEEP:  cmd_o.sweep_step    = 1'b1;
      ST_FINISH: cmd_o.load_calib    = slot_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign load        = cmd_o.commit_sample || cmd_o.load_calib;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/lstc_dp.sv @@
`timescale 1ns / 1ps
// lstc_dp: eye stores, threshold compare, bar bytes, capture sweep and output word register
// depends on lstc_pkg
module lstc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lstc_pkg::lstc_cmd_t                  cmd_i,
  output lstc_pkg::lstc_status_t               status_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic [1:0]                           req_type_i,
  input  logic [1:0]                           bar_select_i,
  input  logic [2:0]                           eye_index_i,
  input  logic [lstc_pkg::SAMPLE_BITS-1:0]     sample_value_i,
  input  logic                                 end_of_scan_i,
  input  logic [lstc_pkg::SAMPLE_BITS-1:0]     new_threshold_i,
  output logic                                 detect_bit_o,
  output logic [lstc_pkg::BYTE_W-1:0]          front_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]          back_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]          left_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]          right_byte_o,
  output logic                                 scan_done_o,
  output logic [lstc_pkg::SAMPLE_BITS-1:0]     calib_average_o,
  output logic                                 calib_done_o
);
  import lstc_pkg::*;

  // latched item
  lstc_req_e              req_q;
  logic [1:0]             bar_q;
  logic [2:0]             eye_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   eos_q;
  logic [SAMPLE_BITS-1:0] nthr_q;

  logic invert_q;

  // per eye stores
  logic [SAMPLE_BITS-1:0] raw_q   [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] thr_q   [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] white_q [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] black_q [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] raw_d   [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] thr_d   [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] white_d [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] black_d [EYE_TOTAL];

  logic [BYTE_W-1:0] part_q [BYTE_COUNT];
  logic [BYTE_W-1:0] part_d [BYTE_COUNT];
  logic [BYTE_W-1:0] pub_q  [BYTE_COUNT];
  logic [BYTE_W-1:0] pub_d  [BYTE_COUNT];

  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  // sample path
  logic [IDX_W-1:0]       idx;
  logic                   in_range;
  logic                   detect;
  logic [BYTE_W-1:0]      bit_mask;
  logic                   inv_eye;

  // sweep path
  logic [SAMPLE_BITS-1:0] raw_rd;
  logic [SAMPLE_BITS-1:0] white_rd;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [SAMPLE_BITS-1:0] mid;
  logic [SAMPLE_BITS-1:0] mid_clamped;
  logic [SUM_W-1:0]       avg_full;

  // output word register
  logic                   det_oq;
  logic                   done_oq;
  logic                   cal_oq;
  logic [SAMPLE_BITS-1:0] avg_oq;
  logic [BYTE_W-1:0]      byte_oq [BYTE_COUNT];

  assign idx      = IDX_W'(32'(bar_q) * EYES_PER_BAR + 32'(eye_q));
  assign in_range = (32'(bar_q) < BAR_COUNT) && (32'(eye_q) < EYES_PER_BAR);
  assign inv_eye  = ((bar_q == BAR_BACK) || (bar_q == BAR_RIGHT)) &&
                    (32'(eye_q) == EYES_PER_BAR - 1);
  assign detect   = in_range && ((smp_q > thr_q[idx]) ^ inv_eye);
  assign bit_mask = 8'h80 >> eye_q;

  assign raw_rd      = raw_q[cnt_q];
  assign white_rd    = white_q[cnt_q];
  assign pair_sum    = {1'b0, white_rd} + {1'b0, raw_rd};
  assign mid         = pair_sum[SAMPLE_BITS:1];
  assign mid_clamped = (mid < THR_LOW) ? THR_LOW : ((mid > THR_HIGH) ? THR_HIGH : mid);
  assign avg_full    = SUM_W'(sum_q / EYE_TOTAL);

  assign status_o.sweep_last = (cnt_q == IDX_W'(EYE_TOTAL - 1));

  always_comb begin
    raw_d   = raw_q;
    thr_d   = thr_q;
    white_d = white_q;
    black_d = black_q;
    part_d  = part_q;
    pub_d   = pub_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;

    if (cmd_i.latch) begin
      cnt_d = '0;
      sum_d = '0;
    end

    if (cmd_i.commit_sample) begin
      if (in_range) begin
        raw_d[idx] = smp_q;
        if (detect) part_d[bar_q] = part_q[bar_q] | bit_mask;
        else        part_d[bar_q] = part_q[bar_q] & ~bit_mask;
      end
      // publish after this sample has updated its bar
      if (eos_q) begin
        for (int b = 0; b < BYTE_COUNT; b++) begin
          pub_d[b]  = invert_q ? ~part_d[b] : part_d[b];
          part_d[b] = '0;
        end
      end
    end

    if (cmd_i.sweep_step) begin
      cnt_d = cnt_q + IDX_W'(1);
      sum_d = sum_q + SUM_W'(raw_rd);
      case (req_q)
        REQ_CAPT_WHITE: white_d[cnt_q] = raw_rd;
        REQ_CAPT_BLACK: begin
          black_d[cnt_q] = raw_rd;
          thr_d[cnt_q]   = mid_clamped;
        end
        REQ_SET_ALL: thr_d[cnt_q] = nthr_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EYE_TOTAL; i++) begin
        raw_q[i]   <= '0;
        thr_q[i]   <= THR_RESET;
        white_q[i] <= WHITE_RESET;
        black_q[i] <= BLACK_RESET;
      end
      for (int b = 0; b < BYTE_COUNT; b++) begin
        part_q[b] <= '0;
        pub_q[b]  <= '0;
      end
      invert_q <= 1'b0;
      cnt_q    <= '0;
      sum_q    <= '0;
      req_q    <= REQ_SAMPLE;
    end else begin
      raw_q   <= raw_d;
      thr_q   <= thr_d;
      white_q <= white_d;
      black_q <= black_d;
      part_q  <= part_d;
      pub_q   <= pub_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      if (cfg_we_i)    invert_q <= cfg_wdata_i;
      if (cmd_i.latch) req_q    <= lstc_req_e'(req_type_i);
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      bar_q  <= bar_select_i;
      eye_q  <= eye_index_i;
      smp_q  <= sample_value_i;
      eos_q  <= end_of_scan_i;
      nthr_q <= new_threshold_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_sample) begin
      det_oq  <= detect;
      done_oq <= eos_q;
      cal_oq  <= 1'b0;
      avg_oq  <= '0;
      byte_oq <= pub_d;
    end else if (cmd_i.load_calib) begin
      det_oq  <= 1'b0;
      done_oq <= 1'b0;
      cal_oq  <= (req_q == REQ_CAPT_WHITE) || (req_q == REQ_CAPT_BLACK);
      avg_oq  <= (req_q == REQ_SET_ALL) ? '0 : SAMPLE_BITS'(avg_full);
      byte_oq <= pub_q;
    end
  end

  assign detect_bit_o    = det_oq;
  assign scan_done_o     = done_oq;
  assign calib_done_o    = cal_oq;
  assign calib_average_o = avg_oq;
  assign front_byte_o    = byte_oq[0];
  assign back_byte_o     = byte_oq[1];
  assign left_byte_o     = byte_oq[2];
  assign right_byte_o    = byte_oq[3];

endmodule

@@ sv/line_sensor_threshold_calibrator_core.sv @@
`timescale 1ns / 1ps
// line sensor threshold calibrator: top level, lstc_ctrl sequencer plus lstc_dp datapath
// sample words: latched on accept; no new word taken until the result enters the output register
// capture and set-all words: a sweep of the eye stores (1 entry a cycle), then the result loads
// the output word register lets a new word in while the last result waits to be taken
// async active-low reset: thresholds 500, white 100, black 900, raw and bar bytes zero,
// invert off, no result pending
module line_sensor_threshold_calibrator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: invert_line register
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       req_type_i,
  input  logic [1:0]                       bar_select_i,
  input  logic [2:0]                       eye_index_i,
  input  logic [lstc_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic                             end_of_scan_i,
  input  logic [lstc_pkg::SAMPLE_BITS-1:0] new_threshold_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             detect_bit_o,
  output logic [lstc_pkg::BYTE_W-1:0]      front_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]      back_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]      left_byte_o,
  output logic [lstc_pkg::BYTE_W-1:0]      right_byte_o,
  output logic                             scan_done_o,
  output logic [lstc_pkg::SAMPLE_BITS-1:0] calib_average_o,
  output logic                             calib_done_o
);
  import lstc_pkg::*;

  lstc_cmd_t    cmd;
  lstc_status_t status;

  // sequencer: idle, commit a sample, sweep the eye stores, deliver a capture or set-all result
  lstc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // stores, compare, bar bytes, sweep accumulator and result word register
  lstc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .bar_select_i    (bar_select_i),
    .eye_index_i     (eye_index_i),
    .sample_value_i  (sample_value_i),
    .end_of_scan_i   (end_of_scan_i),
    .new_threshold_i (new_threshold_i),
    .detect_bit_o    (detect_bit_o),
    .front_byte_o    (front_byte_o),
    .back_byte_o     (back_byte_o),
    .left_byte_o     (left_byte_o),
    .right_byte_o    (right_byte_o),
    .scan_done_o     (scan_done_o),
    .calib_average_o (calib_average_o),
    .calib_done_o    (calib_done_o)
  );

  // one word in flight: after an accept the input side closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  // a result only appears once a word has been worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a word in progress");

  // a word is either a sample or a capture, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(scan_done_o && calib_done_o))
    else $error("scan and capture flags both set");

  // average is only reported on capture words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !calib_done_o |-> calib_average_o == '0)
    else $error("average reported on a non-capture word");

endmodule

@@ test/line_sensor_threshold_calibrator_core_test.sv @@
`timescale 1ns / 1ps
// line_sensor_threshold_calibrator_core_test: self-checking testbench for the calibrator core
// directed threshold, clamp and invert tests, then random scan traffic under four idling mixes
// depends on lstc_pkg and line_sensor_threshold_calibrator_core
module line_sensor_threshold_calibrator_core_test;
  import lstc_pkg::*;

  // bar codes the package does not name
  localparam logic [1:0] BAR_FRONT = 2'd0;
  localparam logic [1:0] BAR_LEFT  = 2'd2;
  localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = {SAMPLE_BITS{1'b1}};
  localparam int PRINT_LIMIT = 40;

  // one expected result word
  typedef struct packed {
    logic                   detect;
    logic [BYTE_W-1:0]      front;
    logic [BYTE_W-1:0]      back;
    logic [BYTE_W-1:0]      left;
    logic [BYTE_W-1:0]      right;
    logic                   scan;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   calib;
  } sensor_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  lstc_req_e              req_type_i;
  logic [1:0]             bar_select_i;
  logic [2:0]             eye_index_i;
  logic [SAMPLE_BITS-1:0] sample_value_i;
  logic                   end_of_scan_i;
  logic [SAMPLE_BITS-1:0] new_threshold_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   detect_bit_o;
  logic [BYTE_W-1:0]      front_byte_o;
  logic [BYTE_W-1:0]      back_byte_o;
  logic [BYTE_W-1:0]      left_byte_o;
  logic [BYTE_W-1:0]      right_byte_o;
  logic                   scan_done_o;
  logic [SAMPLE_BITS-1:0] calib_average_o;
  logic                   calib_done_o;

  // shadow copy of the block state, updated as each word is accepted
  logic [SAMPLE_BITS-1:0] raw_level     [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] eye_threshold [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] white_level   [EYE_TOTAL];
  logic [SAMPLE_BITS-1:0] black_level   [EYE_TOTAL];
  logic [BYTE_W-1:0]      bar_pattern   [BYTE_COUNT];
  logic [BYTE_W-1:0]      shown_pattern [BYTE_COUNT];
  logic                   invert_on;

  // result words still owed by the block, oldest first
  sensor_word_t sensor_words_due[$];
  sensor_word_t want;
  int           mismatch_count;
  int           send_idle_pct;
  int           stall_pct;

  line_sensor_threshold_calibrator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .bar_select_i    (bar_select_i),
    .eye_index_i     (eye_index_i),
    .sample_value_i  (sample_value_i),
    .end_of_scan_i   (end_of_scan_i),
    .new_threshold_i (new_threshold_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .detect_bit_o    (detect_bit_o),
    .front_byte_o    (front_byte_o),
    .back_byte_o     (back_byte_o),
    .left_byte_o     (left_byte_o),
    .right_byte_o    (right_byte_o),
    .scan_done_o     (scan_done_o),
    .calib_average_o (calib_average_o),
    .calib_done_o    (calib_done_o)
  );

  // 10 ns clock, blocking so that posedge reads see pre-edge register values
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side backpressure, redrawn every falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // state after reset, as the block comes out of it
  task automatic reset_shadow();
    for (int i = 0; i < EYE_TOTAL; i++) begin
      raw_level[i]     = '0;
      eye_threshold[i] = THR_RESET;
      white_level[i]   = WHITE_RESET;
      black_level[i]   = BLACK_RESET;
    end
    for (int i = 0; i < BYTE_COUNT; i++) begin
      bar_pattern[i]   = '0;
      shown_pattern[i] = '0;
    end
    invert_on = 1'b0;
  endtask

  // expected result of one accepted word; also advances the shadow state
  function automatic sensor_word_t predict_sensor_word(lstc_req_e req, logic [1:0] bar,
      logic [2:0] eye, logic [SAMPLE_BITS-1:0] level, logic eos,
      logic [SAMPLE_BITS-1:0] thr);
    sensor_word_t r;
    int           idx;
    int           total;
    int           mid;
    r = '0;
    case (req)
      REQ_SAMPLE: begin
        idx = bar * EYES_PER_BAR + eye;
        raw_level[idx] = level;
        r.detect = (level > eye_threshold[idx]);
        // last eye on the back and right bars reads inverted
        if ((bar == BAR_BACK || bar == BAR_RIGHT) && eye == EYES_PER_BAR - 1)
          r.detect = ~r.detect;
        bar_pattern[bar][7 - eye] = r.detect;
        if (eos) begin
          for (int i = 0; i < BYTE_COUNT; i++) begin
            shown_pattern[i] = invert_on ? ~bar_pattern[i] : bar_pattern[i];
            bar_pattern[i]   = '0;
          end
          r.scan = 1'b1;
        end
      end
      REQ_CAPT_WHITE, REQ_CAPT_BLACK: begin
        total = 0;
        for (int i = 0; i < EYE_TOTAL; i++) begin
          if (req == REQ_CAPT_WHITE) white_level[i] = raw_level[i];
          else black_level[i] = raw_level[i];
          total += raw_level[i];
        end
        if (req == REQ_CAPT_BLACK) begin
          for (int i = 0; i < EYE_TOTAL; i++) begin
            mid = (white_level[i] + black_level[i]) / 2;
            if (mid < THR_LOW) mid = THR_LOW;
            if (mid > THR_HIGH) mid = THR_HIGH;
            eye_threshold[i] = mid[SAMPLE_BITS-1:0];
          end
        end
        r.avg   = SAMPLE_BITS'(total / EYE_TOTAL);
        r.calib = 1'b1;
      end
      default: begin
        for (int i = 0; i < EYE_TOTAL; i++) eye_threshold[i] = thr;
      end
    endcase
    r.front = shown_pattern[0];
    r.back  = shown_pattern[1];
    r.left  = shown_pattern[2];
    r.right = shown_pattern[3];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch on %0s: got %0d, want %0d at %0t", what, got_v, want_v, $realtime);
  endtask

  // result checker: every taken word is held against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (sensor_words_due.size() == 0) begin
        report_mismatch("word with nothing expected", 1, 0);
      end else begin
        want = sensor_words_due.pop_front();
        if (detect_bit_o !== want.detect)
          report_mismatch("detect_bit", detect_bit_o, want.detect);
        if (front_byte_o !== want.front)
          report_mismatch("front_byte", front_byte_o, want.front);
        if (back_byte_o !== want.back)
          report_mismatch("back_byte", back_byte_o, want.back);
        if (left_byte_o !== want.left)
          report_mismatch("left_byte", left_byte_o, want.left);
        if (right_byte_o !== want.right)
          report_mismatch("right_byte", right_byte_o, want.right);
        if (scan_done_o !== want.scan)
          report_mismatch("scan_done", scan_done_o, want.scan);
        if (calib_average_o !== want.avg)
          report_mismatch("calib_average", calib_average_o, want.avg);
        if (calib_done_o !== want.calib)
          report_mismatch("calib_done", calib_done_o, want.calib);
      end
    end
  end

  // drive one input word; valid is only lowered when the sender takes a break
  task automatic send_word(lstc_req_e req, logic [1:0] bar, logic [2:0] eye,
      logic [SAMPLE_BITS-1:0] level, logic eos, logic [SAMPLE_BITS-1:0] thr);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    bar_select_i    <= bar;
    eye_index_i     <= eye;
    sample_value_i  <= level;
    end_of_scan_i   <= eos;
    new_threshold_i <= thr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sensor_words_due.push_back(predict_sensor_word(req, bar, eye, level, eos, thr));
  endtask

  // drop valid and wait until every owed word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sensor_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_invert(logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    invert_on = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // levels lean toward the extremes and the calibrated band
  function automatic logic [SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return LEVEL_MAX;
      2, 3:    return SAMPLE_BITS'($urandom_range(900, 100));
      default: return SAMPLE_BITS'($urandom_range(LEVEL_MAX));
    endcase
  endfunction

  // strict compare, zero and full-scale thresholds, eye 7 inversion, publish
  task automatic test_threshold_extremes();
    send_word(REQ_SET_ALL, BAR_FRONT, 3'd0, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, 10'd1, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd1, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_BACK, 3'd7, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_RIGHT, 3'd7, LEVEL_MAX, 1'b0, LEVEL_MAX);
    send_word(REQ_SAMPLE, BAR_LEFT, 3'd7, LEVEL_MAX, 1'b1, '0);
    // end of scan on a command does not publish
    send_word(REQ_SET_ALL, BAR_FRONT, 3'd0, LEVEL_MAX, 1'b1, LEVEL_MAX);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, LEVEL_MAX, 1'b1, '0);
  endtask

  // midpoints clamped at both ends, then an unclamped midpoint
  task automatic test_calibration_clamp();
    send_word(REQ_CAPT_WHITE, BAR_RIGHT, 3'd7, LEVEL_MAX, 1'b1, LEVEL_MAX);
    send_word(REQ_CAPT_BLACK, BAR_FRONT, 3'd0, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, 10'd850, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, 10'd851, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd1, 10'd150, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd1, 10'd151, 1'b1, '0);
    send_word(REQ_CAPT_WHITE, BAR_FRONT, 3'd0, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, '0, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd1, LEVEL_MAX, 1'b0, '0);
    send_word(REQ_CAPT_BLACK, BAR_LEFT, 3'd3, LEVEL_MAX, 1'b0, LEVEL_MAX);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, 10'd426, 1'b1, '0);
  endtask

  // published bytes inverted for a white line on a dark floor
  task automatic test_inverted_publish();
    write_invert(1'b1);
    send_word(REQ_SAMPLE, BAR_BACK, 3'd3, '0, 1'b1, '0);
    send_word(REQ_SAMPLE, BAR_FRONT, 3'd0, LEVEL_MAX, 1'b0, '0);
    send_word(REQ_SAMPLE, BAR_RIGHT, 3'd7, '0, 1'b1, '0);
  endtask

  // mostly whole scans with random levels, plus broken scans, commands and noise
  task automatic test_scan_traffic(int words, int sender_pct, int receiver_pct, logic inv);
    int sent;
    int pick;
    int first;
    int len;
    int idx;
    write_invert(inv);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        for (int i = 0; i < EYE_TOTAL; i++)
          send_word(REQ_SAMPLE, 2'(i / EYES_PER_BAR), 3'(i % EYES_PER_BAR), pick_level(),
                    (i == EYE_TOTAL - 1), SAMPLE_BITS'($urandom));
        sent += EYE_TOTAL;
        // calibrate or set all thresholds right after a full scan half of the time
        if ($urandom_range(1) == 0) begin
          send_word(lstc_req_e'($urandom_range(3, 1)), 2'($urandom), 3'($urandom),
                    SAMPLE_BITS'($urandom), 1'($urandom), pick_level());
          sent++;
        end
      end else if (pick < 80) begin
        // broken scan: runs from anywhere, ends with or without a publish
        first = $urandom_range(EYE_TOTAL - 1);
        len   = $urandom_range(EYE_TOTAL - 1, 1);
        for (int i = 0; i < len; i++) begin
          idx = (first + i) % EYE_TOTAL;
          send_word(REQ_SAMPLE, 2'(idx / EYES_PER_BAR), 3'(idx % EYES_PER_BAR), pick_level(),
                    (i == len - 1) && ($urandom_range(1) == 0), SAMPLE_BITS'($urandom));
        end
        sent += len;
      end else if (pick < 90) begin
        send_word(lstc_req_e'($urandom_range(3, 1)), 2'($urandom), 3'($urandom),
                  SAMPLE_BITS'($urandom), 1'($urandom), pick_level());
        sent++;
      end else begin
        send_word(lstc_req_e'($urandom_range(3)), 2'($urandom), 3'($urandom),
                  SAMPLE_BITS'($urandom), 1'($urandom), SAMPLE_BITS'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    mismatch_count  = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_SAMPLE;
    bar_select_i    = '0;
    eye_index_i     = '0;
    sample_value_i  = '0;
    end_of_scan_i   = 1'b0;
    new_threshold_i = '0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_threshold_extremes();
    test_calibration_clamp();
    test_inverted_publish();
    // idling mixes: none, slow sender, slow receiver, both lightly
    test_scan_traffic(310, 0, 0, 1'b0);
    test_scan_traffic(310, 83, 0, 1'b1);
    test_scan_traffic(310, 0, 83, 1'b0);
    test_scan_traffic(310, 12, 12, 1'b1);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
